// ===== sv/msr_pkg.sv =====
// Shared types, constants and curve-table builders for the motor soft start/stop ramp.
// No dependencies; every other file imports this package.
package msr_pkg;

  // Field widths
  localparam int STEP_W     = 7;
  localparam int TAB_DEPTH  = 1 << STEP_W;
  localparam int FRAC_W     = 16;
  localparam int LEVEL_W    = 16;
  localparam int FLOOR_W    = 15;
  localparam int MAG_W      = 17;
  localparam int PROD_W     = MAG_W + FRAC_W;
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // Default ramp lengths in ticks
  localparam int UP_STEPS_DEF   = 100;
  localparam int DOWN_STEPS_DEF = 120;

  // Floor register reset values
  localparam logic [FLOOR_W-1:0] RISE_FLOOR_RST  = FLOOR_W'(30);
  localparam logic [FLOOR_W-1:0] BRAKE_FLOOR_RST = FLOOR_W'(42);

  // Action codes
  localparam logic [MODE_W-1:0] MODE_RISE_RESTART  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RISE_ABORT    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RISE_ADVANCE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_BRAKE_RESTART = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BRAKE_ABORT   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_BRAKE_ADVANCE = 3'd5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RISE_FLOOR  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRAKE_FLOOR = 8'd1;

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic signed [LEVEL_W-1:0] target;
  } msr_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] drive;
    logic [LEVEL_W-1:0] rise_level;
    logic [LEVEL_W-1:0] brake_level;
    logic               rise_running;
    logic               brake_running;
  } msr_result_t;

  typedef struct packed {
    logic [FLOOR_W-1:0] rise_floor;
    logic [FLOOR_W-1:0] brake_floor;
  } msr_floors_t;

  typedef logic [TAB_DEPTH-1:0][FRAC_W-1:0] frac_tab_t;

  // Q0.16 floor(65536 * sqrt(s / up)); evaluated at elaboration only
  function automatic frac_tab_t rise_table(input int up);
    frac_tab_t tab;
    longint    lo;
    longint    hi;
    longint    mid;
    longint    rhs;
    for (int s = 0; s < TAB_DEPTH; s++) begin
      rhs = longint'(s) << 32;
      lo  = 0;
      hi  = 65536;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        if (mid * mid * longint'(up) <= rhs) lo = mid;
        else hi = mid - 1;
      end
      tab[s] = FRAC_W'(lo);
    end
    return tab;
  endfunction

  // Q0.16 floor(65536 * (1 - (s / down)^1.5)); evaluated at elaboration only
  function automatic frac_tab_t brake_table(input int down);
    frac_tab_t tab;
    longint    lo;
    longint    hi;
    longint    mid;
    longint    rhs;
    longint    d3;
    d3 = longint'(down) * longint'(down) * longint'(down);
    for (int s = 0; s < TAB_DEPTH; s++) begin
      rhs = (longint'(s) * longint'(s) * longint'(s)) << 32;
      lo  = 0;
      hi  = 65536;
      while (lo < hi) begin
        mid = (lo + hi) >> 1;
        if (mid * mid * d3 >= rhs) hi = mid;
        else lo = mid + 1;
      end
      tab[s] = FRAC_W'(65536 - lo);
    end
    return tab;
  endfunction

endpackage

// ===== sv/msr_cfg.sv =====
// Floor configuration registers for the ramp generator.
// Depends on msr_pkg.
module msr_cfg import msr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output msr_floors_t           floors
);

  // Always able to take a write beat
  assign cfg_ready = 1'b1;

  // Register file; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      floors.rise_floor  <= RISE_FLOOR_RST;
      floors.brake_floor <= BRAKE_FLOOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RISE_FLOOR:  floors.rise_floor  <= cfg_data[FLOOR_W-1:0];
        REG_BRAKE_FLOOR: floors.brake_floor <= cfg_data[FLOOR_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/msr_core.sv =====
// Ramp state registers and the single-pass step logic: table lookup, one shared
// multiplier, floor clamp. Depends on msr_pkg.
module msr_core import msr_pkg::*; #(
  parameter int UP_STEPS   = UP_STEPS_DEF,
  parameter int DOWN_STEPS = DOWN_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  msr_item_t   item,
  input  msr_floors_t floors,
  output msr_result_t result_next
);

  localparam frac_tab_t RiseTab  = rise_table(UP_STEPS);
  localparam frac_tab_t BrakeTab = brake_table(DOWN_STEPS);
  localparam logic [STEP_W-1:0] UpLast   = STEP_W'(UP_STEPS);
  localparam logic [STEP_W-1:0] DownLast = STEP_W'(DOWN_STEPS);

  // Ramp state
  logic               rise_active, rise_active_next;
  logic [STEP_W-1:0]  rise_step, rise_step_next;
  logic [LEVEL_W-1:0] rise_value, rise_value_next;
  logic               brake_active, brake_active_next;
  logic [STEP_W-1:0]  brake_step, brake_step_next;
  logic [LEVEL_W-1:0] brake_value, brake_value_next;

  logic [MAG_W-1:0]   mag;
  logic [STEP_W-1:0]  rise_inc;
  logic [STEP_W-1:0]  brake_inc;
  logic               brake_sel;
  logic [FRAC_W-1:0]  frac;
  logic [PROD_W-1:0]  prod;
  logic [LEVEL_W-1:0] scaled;
  logic [LEVEL_W-1:0] floor_val;
  logic [LEVEL_W-1:0] floored;
  logic [LEVEL_W-1:0] drive;

  // Magnitude of the signed target, 0..32768
  assign mag = item.target[LEVEL_W-1] ? (MAG_W'(17'h10000) - {1'b0, item.target})
                                      : {1'b0, item.target};

  // Next step counts; brake saturates at its last step
  assign rise_inc  = rise_step + 1'b1;
  assign brake_inc = (brake_step < DownLast) ? brake_step + 1'b1 : brake_step;

  // Shared lookup, multiply and floor clamp
  assign brake_sel = (item.mode == MODE_BRAKE_ADVANCE);
  assign frac      = brake_sel ? BrakeTab[brake_inc] : RiseTab[rise_inc];
  assign prod      = PROD_W'(mag) * PROD_W'(frac);
  assign scaled    = LEVEL_W'(prod >> FRAC_W);
  assign floor_val = brake_sel ? {1'b0, floors.brake_floor} : {1'b0, floors.rise_floor};
  assign floored   = (scaled < floor_val) ? floor_val : scaled;

  // Action decode
  always_comb begin
    rise_active_next  = rise_active;
    rise_step_next    = rise_step;
    rise_value_next   = rise_value;
    brake_active_next = brake_active;
    brake_step_next   = brake_step;
    brake_value_next  = brake_value;
    drive             = '0;
    unique case (item.mode)
      MODE_RISE_RESTART, MODE_RISE_ABORT: begin
        rise_active_next = (item.mode == MODE_RISE_RESTART);
        rise_step_next   = '0;
        rise_value_next  = '0;
      end
      MODE_RISE_ADVANCE: begin
        if (rise_inc >= UpLast) begin
          // ramp finished: full magnitude, then back to rest
          rise_active_next = 1'b0;
          rise_step_next   = '0;
          rise_value_next  = '0;
          drive            = LEVEL_W'(mag);
        end else begin
          rise_step_next  = rise_inc;
          rise_value_next = (mag == '0) ? '0 : floored;
          drive           = rise_value_next;
        end
      end
      MODE_BRAKE_RESTART, MODE_BRAKE_ABORT: begin
        brake_active_next = (item.mode == MODE_BRAKE_RESTART);
        brake_step_next   = '0;
        brake_value_next  = '0;
      end
      MODE_BRAKE_ADVANCE: begin
        brake_step_next  = brake_inc;
        brake_value_next = floored;
        drive            = floored;
      end
      default: ;
    endcase
  end

  assign result_next.drive         = drive;
  assign result_next.rise_level    = rise_value_next;
  assign result_next.brake_level   = brake_value_next;
  assign result_next.rise_running  = rise_active_next;
  assign result_next.brake_running = brake_active_next;

  // State update once per beat
  always_ff @(posedge clk) begin
    if (rst) begin
      rise_active  <= 1'b0;
      rise_step    <= '0;
      rise_value   <= '0;
      brake_active <= 1'b0;
      brake_step   <= '0;
      brake_value  <= '0;
    end else if (fire) begin
      rise_active  <= rise_active_next;
      rise_step    <= rise_step_next;
      rise_value   <= rise_value_next;
      brake_active <= brake_active_next;
      brake_step   <= brake_step_next;
      brake_value  <= brake_value_next;
    end
  end

endmodule

// ===== sv/motor_soft_start_stop_ramp.sv =====
// Motor soft start/stop ramp generator, top level. Uses msr_pkg, msr_cfg, msr_core.
// Two register stages: the input register, then the result register.
// Throughput: one beat per cycle while the result register is not stalled; the ramp state updates in
// the same cycle the beat leaves the input register, so back-to-back beats see it.
// Reset (rst, synchronous): empties both pipeline registers, clears the ramp
// state and loads rise_floor = 30, brake_floor = 42.
module motor_soft_start_stop_ramp import msr_pkg::*; #(
  parameter int UP_STEPS   = UP_STEPS_DEF,
  parameter int DOWN_STEPS = DOWN_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  msr_item_t             item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output msr_result_t           result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic        stage_valid;
  msr_item_t   stage_item;
  logic        advance;
  logic        fire;
  msr_floors_t floors;
  msr_result_t result_next;

  // Handshake: input register moves whenever the result register is free
  assign advance    = !result_valid || !result_stall;
  assign item_stall = stage_valid && !advance;
  assign fire       = stage_valid && advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!item_stall) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      stage_item <= item;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= result_next;
    end
  end

  msr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .floors    (floors)
  );

  msr_core #(
    .UP_STEPS   (UP_STEPS),
    .DOWN_STEPS (DOWN_STEPS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .item        (stage_item),
    .floors      (floors),
    .result_next (result_next)
  );

endmodule

// ===== sv/msr_checker.sv =====
// Port-level checks for the ramp generator, bound to the top level.
// Depends on msr_pkg.
module msr_checker import msr_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        item_stall,
  input logic        result_valid,
  input logic        result_stall,
  input msr_result_t result
);

  localparam logic [LEVEL_W-1:0] LevelMax = LEVEL_W'(32768);

  // A stalled result beat holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  // Input side stalls only when the result register is full and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && result_stall)
    else $error("input stalled with a free result register");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  // Ramp outputs never exceed the full-scale magnitude
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.drive <= LevelMax && result.rise_level <= LevelMax &&
                     result.brake_level <= LevelMax)
    else $error("ramp level beyond full scale");

endmodule

bind motor_soft_start_stop_ramp msr_checker u_msr_checker (
  .clk          (clk),
  .rst          (rst),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
